[hdl/tvt_pkg.sv]
package tvt_pkg;

  // Table size and field widths
  localparam int DEFAULT_DEPTH = 256;
  localparam int FUNC_W        = 3;
  localparam int INDEX_W       = 9;
  localparam int COMP_W        = 32;
  localparam int VEC_W         = 4 * COMP_W;
  localparam int STATUS_W      = 2;
  localparam int RIDX_W        = 8;
  localparam int TOTAL_W       = 9;
  localparam int TOL_W         = 31;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_FIND   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SORT   = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEDUPE = 3'd5;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd6;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // Ordering of two vectors under the tolerance
  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } ord_t;

  typedef struct packed {
    logic             start;
    logic [VEC_W-1:0] a;
    logic [VEC_W-1:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    ord_t ord;
  } cmp_rsp_t;

endpackage

[hdl/tvt_if.sv]
interface tvt_in_if;
  logic                          valid;
  logic                          ready;
  logic [tvt_pkg::FUNC_W-1:0]    func;
  logic [tvt_pkg::INDEX_W-1:0]   index;
  logic                          use_binary;
  logic signed [tvt_pkg::COMP_W-1:0] vec_x;
  logic signed [tvt_pkg::COMP_W-1:0] vec_y;
  logic signed [tvt_pkg::COMP_W-1:0] vec_z;
  logic signed [tvt_pkg::COMP_W-1:0] vec_w;

  modport source (output valid, func, index, use_binary, vec_x, vec_y, vec_z, vec_w,
                  input ready);
  modport sink   (input valid, func, index, use_binary, vec_x, vec_y, vec_z, vec_w,
                  output ready);
endinterface

interface tvt_out_if;
  logic                          valid;
  logic                          ready;
  logic [tvt_pkg::STATUS_W-1:0]  status;
  logic [tvt_pkg::RIDX_W-1:0]    result_index;
  logic [tvt_pkg::TOTAL_W-1:0]   entry_total;

  modport source (output valid, status, result_index, entry_total, input ready);
  modport sink   (input valid, status, result_index, entry_total, output ready);
endinterface

[hdl/tvt_cmp.sv]
module tvt_cmp (
  input  logic                       clk,
  input  logic                       rst,
  input  tvt_pkg::cmp_req_t          req,
  input  logic [tvt_pkg::TOL_W-1:0]  tol,
  output tvt_pkg::cmp_rsp_t          rsp
);

  localparam int DW = tvt_pkg::COMP_W + 2;

  logic [tvt_pkg::VEC_W-1:0]  ra;
  logic [tvt_pkg::VEC_W-1:0]  rb;
  logic [1:0]                 comp;
  logic                       busy;
  logic                       done;
  tvt_pkg::ord_t              ord;
  logic [tvt_pkg::COMP_W-1:0] ca;
  logic [tvt_pkg::COMP_W-1:0] cb;
  logic signed [DW-1:0]       diff;
  logic signed [DW-1:0]       tol_s;
  logic                       above;
  logic                       below;

  // Exact difference of one component against the tolerance band
  always_comb begin
    ca    = ra[comp*tvt_pkg::COMP_W +: tvt_pkg::COMP_W];
    cb    = rb[comp*tvt_pkg::COMP_W +: tvt_pkg::COMP_W];
    diff  = signed'({{2{ca[tvt_pkg::COMP_W-1]}}, ca}) - signed'({{2{cb[tvt_pkg::COMP_W-1]}}, cb});
    tol_s = signed'({3'b000, tol});
    above = diff > tol_s;
    below = diff < -tol_s;
  end

  // Walk x, y, z, w; stop at the first component outside the band
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      comp <= 2'd0;
      ord  <= tvt_pkg::ORD_EQ;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        comp <= 2'd0;
        ra   <= req.a;
        rb   <= req.b;
      end else if (busy) begin
        if (above || below) begin
          ord  <= above ? tvt_pkg::ORD_GT : tvt_pkg::ORD_LT;
          done <= 1'b1;
          busy <= 1'b0;
        end else if (comp == 2'd3) begin
          ord  <= tvt_pkg::ORD_EQ;
          done <= 1'b1;
          busy <= 1'b0;
        end else begin
          comp <= comp + 2'd1;
        end
      end
    end
  end

  assign rsp = '{done: done, ord: ord};

endmodule

[hdl/tolerant_vector_table.sv]
// Channel | Modport     | Moves
// --------+-------------+------------------------------------------------
// req     | tvt_in_if   | func, index, use_binary, vec_x/y/z/w (one op)
// rsp     | tvt_out_if  | status, result_index, entry_total (one per op)
// cfg     | we + wdata  | tolerance (Q15.16, 31 bit)
//
// One operation at a time; req.ready is high only between operations.
// Append and clear do not walk the table. Insert/delete move one entry per read/write
// pair. Find reads an entry and runs one compare per linear or binary probe;
// sort and dedupe run compares plus stack and swap steps. Operations are serial
// over the vector store (one read and one write port) and the component-serial
// compare unit (one 34-bit component compare per cycle).
// Reset clears the entry count and stack pointer; the vector store is not cleared.
// A result waiting on rsp holds the block in its final state until taken.
module tolerant_vector_table #(
  parameter int TABLE_DEPTH = tvt_pkg::DEFAULT_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst,
  tvt_in_if.sink                    req,
  tvt_out_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [tvt_pkg::TOL_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = AW + 2;
  localparam int VW = tvt_pkg::VEC_W;

  typedef enum logic [37:0] {
    S_IDLE    = 38'b1 << 0,
    S_DONE    = 38'b1 << 1,
    S_UP_RD   = 38'b1 << 2,
    S_UP_WR   = 38'b1 << 3,
    S_WRV     = 38'b1 << 4,
    S_DN_RD   = 38'b1 << 5,
    S_DN_WR   = 38'b1 << 6,
    S_LF_RD   = 38'b1 << 7,
    S_LF_CMP  = 38'b1 << 8,
    S_LF_WAIT = 38'b1 << 9,
    S_BF_TEST = 38'b1 << 10,
    S_BF_RD   = 38'b1 << 11,
    S_BF_CMP  = 38'b1 << 12,
    S_BF_WAIT = 38'b1 << 13,
    S_POP     = 38'b1 << 14,
    S_POP2    = 38'b1 << 15,
    S_PIV     = 38'b1 << 16,
    S_IS      = 38'b1 << 17,
    S_IS_CMP  = 38'b1 << 18,
    S_IS_WAIT = 38'b1 << 19,
    S_JS      = 38'b1 << 20,
    S_JS_CMP  = 38'b1 << 21,
    S_JS_WAIT = 38'b1 << 22,
    S_SWP     = 38'b1 << 23,
    S_SW1     = 38'b1 << 24,
    S_SW2     = 38'b1 << 25,
    S_SW3     = 38'b1 << 26,
    S_LOOP    = 38'b1 << 27,
    S_PUSH1   = 38'b1 << 28,
    S_PUSH2   = 38'b1 << 29,
    S_CLR     = 38'b1 << 30,
    S_DO      = 38'b1 << 31,
    S_DO_M    = 38'b1 << 32,
    S_DI      = 38'b1 << 33,
    S_DI_M    = 38'b1 << 34,
    S_DI_WAIT = 38'b1 << 35,
    S_CP_RD   = 38'b1 << 36,
    S_CP_WR   = 38'b1 << 37
  } state_t;

  state_t                         state, state_next;
  logic [CW-1:0]                  count, count_next;
  logic [CW-1:0]                  top, top_next;
  logic [CW-1:0]                  k, k_next;
  logic signed [SW-1:0]           i, i_next;
  logic signed [SW-1:0]           j, j_next;
  logic [AW-1:0]                  m, m_next;
  logic                           last, last_next;
  logic [AW-1:0]                  lo, lo_next;
  logic [AW-1:0]                  hi, hi_next;
  logic [VW-1:0]                  vec_r, vec_next;
  logic [VW-1:0]                  piv, piv_next;
  logic [VW-1:0]                  ta, ta_next;
  logic [tvt_pkg::STATUS_W-1:0]   st_r, st_next;
  logic [AW-1:0]                  ri_r, ri_next;
  logic [tvt_pkg::TOL_W-1:0]      tol;

  // Vector store, mark store and range stack
  logic [VW-1:0]   store [TABLE_DEPTH];
  logic [VW-1:0]   rdata;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  logic            mem_we;
  logic [VW-1:0]   mem_wdata;
  logic            marks [TABLE_DEPTH];
  logic            mark_rd;
  logic [AW-1:0]   mark_raddr, mark_waddr;
  logic            mark_we, mark_wdata;
  logic [2*AW-1:0] stk [TABLE_DEPTH];
  logic [2*AW-1:0] stk_rd;
  logic [AW-1:0]   stk_raddr, stk_waddr;
  logic            stk_we;
  logic [2*AW-1:0] stk_wdata;

  // Result register
  logic                           o_valid, o_load;
  logic [tvt_pkg::STATUS_W-1:0]   o_status;
  logic [tvt_pkg::RIDX_W-1:0]     o_index;
  logic [tvt_pkg::TOTAL_W-1:0]    o_total;

  tvt_pkg::cmp_req_t cmp_req;
  tvt_pkg::cmp_rsp_t cmp_rsp;

  logic [VW-1:0]        in_vec;
  logic [31:0]          cnt32, idx32, ins32, ri32, cntn32;
  logic signed [SW-1:0] lo_s, hi_s, cnt_s, m_s, i_p1;
  logic signed [SW:0]   bsum;
  logic [AW:0]          psum;
  logic [AW-1:0]        lo_rd, hi_rd;

  tvt_cmp u_cmp (
    .clk (clk),
    .rst (rst),
    .req (cmp_req),
    .tol (tol),
    .rsp (cmp_rsp)
  );

  assign in_vec    = {req.vec_w, req.vec_z, req.vec_y, req.vec_x};
  assign req.ready = (state == S_IDLE);
  assign cnt32     = 32'(count);
  assign idx32     = 32'(req.index);
  assign ri32      = 32'(ri_r);
  assign lo_s      = signed'({2'b00, lo});
  assign hi_s      = signed'({2'b00, hi});
  assign cnt_s     = signed'({1'b0, count});
  assign m_s       = signed'({2'b00, m});
  assign i_p1      = i + SW'(1);
  assign bsum      = {i[SW-1], i} + {j[SW-1], j};
  assign lo_rd     = stk_rd[2*AW-1:AW];
  assign hi_rd     = stk_rd[AW-1:0];
  assign psum      = {1'b0, lo_rd} + {1'b0, hi_rd};

  // Sequencer
  always_comb begin
    state_next = state;
    count_next = count;
    top_next   = top;
    k_next     = k;
    i_next     = i;
    j_next     = j;
    m_next     = m;
    last_next  = last;
    lo_next    = lo;
    hi_next    = hi;
    vec_next   = vec_r;
    piv_next   = piv;
    ta_next    = ta;
    st_next    = st_r;
    ri_next    = ri_r;
    ins32      = '0;
    mem_raddr  = '0;
    mem_waddr  = '0;
    mem_we     = 1'b0;
    mem_wdata  = rdata;
    mark_raddr = '0;
    mark_waddr = '0;
    mark_we    = 1'b0;
    mark_wdata = 1'b0;
    stk_raddr  = '0;
    stk_waddr  = '0;
    stk_we     = 1'b0;
    stk_wdata  = '0;
    o_load     = 1'b0;
    cmp_req    = '{start: 1'b0, a: rdata, b: vec_r};

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          vec_next   = in_vec;
          st_next    = tvt_pkg::ST_OK;
          ri_next    = '0;
          state_next = S_DONE;
          unique case (req.func)
            tvt_pkg::FN_APPEND, tvt_pkg::FN_INSERT: begin
              ins32 = (req.func == tvt_pkg::FN_APPEND) ? cnt32 : idx32;
              if (cnt32 >= 32'(TABLE_DEPTH)) begin
                st_next = tvt_pkg::ST_FULL;
              end else if (ins32 > cnt32) begin
                st_next = tvt_pkg::ST_BAD_INDEX;
              end else begin
                i_next     = signed'(SW'(ins32));
                k_next     = count;
                state_next = (cnt32 > ins32) ? S_UP_RD : S_WRV;
              end
            end
            tvt_pkg::FN_DELETE: begin
              if (idx32 >= cnt32) begin
                st_next = tvt_pkg::ST_BAD_INDEX;
              end else begin
                k_next = CW'(idx32 + 32'd1);
                if (idx32 + 32'd1 < cnt32) state_next = S_DN_RD;
                else count_next = count - CW'(1);
              end
            end
            tvt_pkg::FN_FIND: begin
              if (count == '0) begin
                st_next = tvt_pkg::ST_NOT_FOUND;
              end else if (req.use_binary) begin
                i_next     = '0;
                j_next     = signed'(SW'(cnt32 - 32'd1));
                state_next = S_BF_TEST;
              end else begin
                k_next     = '0;
                state_next = S_LF_RD;
              end
            end
            tvt_pkg::FN_SORT: begin
              if (cnt32 >= 32'd2) begin
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = {AW'(0), AW'(cnt32 - 32'd1)};
                top_next   = CW'(1);
                state_next = S_POP;
              end
            end
            tvt_pkg::FN_DEDUPE: begin
              if (count != '0) begin
                k_next     = '0;
                state_next = S_CLR;
              end
            end
            tvt_pkg::FN_CLEAR: count_next = '0;
            default: ;
          endcase
        end
      end

      // Hold the finished result until the output slot frees up
      S_DONE: begin
        if (!o_valid || rsp.ready) begin
          o_load     = 1'b1;
          state_next = S_IDLE;
        end
      end

      // Insert: move entries up from the end, then drop the vector in
      S_UP_RD: begin
        mem_raddr  = AW'(k - CW'(1));
        state_next = S_UP_WR;
      end
      S_UP_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = k[AW-1:0];
        k_next     = k - CW'(1);
        state_next = (signed'({1'b0, k - CW'(1)}) > i) ? S_UP_RD : S_WRV;
      end
      S_WRV: begin
        mem_we     = 1'b1;
        mem_waddr  = i[AW-1:0];
        mem_wdata  = vec_r;
        count_next = count + CW'(1);
        ri_next    = i[AW-1:0];
        state_next = S_DONE;
      end

      // Delete: move later entries down by one
      S_DN_RD: begin
        mem_raddr  = k[AW-1:0];
        state_next = S_DN_WR;
      end
      S_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(k - CW'(1));
        k_next    = k + CW'(1);
        if (k + CW'(1) < count) begin
          state_next = S_DN_RD;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end

      // Linear find
      S_LF_RD: begin
        mem_raddr  = k[AW-1:0];
        state_next = S_LF_CMP;
      end
      S_LF_CMP: begin
        cmp_req    = '{start: 1'b1, a: rdata, b: vec_r};
        state_next = S_LF_WAIT;
      end
      S_LF_WAIT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.ord == tvt_pkg::ORD_EQ) begin
            ri_next    = k[AW-1:0];
            state_next = S_DONE;
          end else if (k + CW'(1) < count) begin
            k_next     = k + CW'(1);
            state_next = S_LF_RD;
          end else begin
            st_next    = tvt_pkg::ST_NOT_FOUND;
            state_next = S_DONE;
          end
        end
      end

      // Binary find over [i, j]; the last probe runs when the range is one entry
      S_BF_TEST: begin
        if (i < j) begin
          m_next     = bsum[AW:1];
          last_next  = 1'b0;
          state_next = S_BF_RD;
        end else if (i == j) begin
          m_next     = i[AW-1:0];
          last_next  = 1'b1;
          state_next = S_BF_RD;
        end else begin
          st_next    = tvt_pkg::ST_NOT_FOUND;
          state_next = S_DONE;
        end
      end
      S_BF_RD: begin
        mem_raddr  = m;
        state_next = S_BF_CMP;
      end
      S_BF_CMP: begin
        cmp_req    = '{start: 1'b1, a: rdata, b: vec_r};
        state_next = S_BF_WAIT;
      end
      S_BF_WAIT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.ord == tvt_pkg::ORD_EQ) begin
            ri_next    = m;
            state_next = S_DONE;
          end else if (last) begin
            st_next    = tvt_pkg::ST_NOT_FOUND;
            state_next = S_DONE;
          end else begin
            if (cmp_rsp.ord == tvt_pkg::ORD_GT) j_next = m_s - SW'(1);
            else i_next = m_s + SW'(1);
            state_next = S_BF_TEST;
          end
        end
      end

      // Sort: pop a range and fetch its middle entry as pivot
      S_POP: begin
        if (top == '0) begin
          state_next = S_DONE;
        end else begin
          stk_raddr  = AW'(top - CW'(1));
          top_next   = top - CW'(1);
          state_next = S_POP2;
        end
      end
      S_POP2: begin
        lo_next    = lo_rd;
        hi_next    = hi_rd;
        i_next     = signed'({2'b00, lo_rd});
        j_next     = signed'({2'b00, hi_rd});
        mem_raddr  = psum[AW:1];
        state_next = S_PIV;
      end
      S_PIV: begin
        piv_next   = rdata;
        state_next = S_IS;
      end

      // Advance i past entries below the pivot
      S_IS: begin
        if (i < hi_s) begin
          mem_raddr  = i[AW-1:0];
          state_next = S_IS_CMP;
        end else begin
          state_next = S_JS;
        end
      end
      S_IS_CMP: begin
        cmp_req    = '{start: 1'b1, a: rdata, b: piv};
        state_next = S_IS_WAIT;
      end
      S_IS_WAIT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.ord == tvt_pkg::ORD_LT) begin
            i_next     = i_p1;
            state_next = S_IS;
          end else begin
            state_next = S_JS;
          end
        end
      end

      // Retreat j past entries above the pivot
      S_JS: begin
        if (j > lo_s) begin
          mem_raddr  = j[AW-1:0];
          state_next = S_JS_CMP;
        end else begin
          state_next = S_SWP;
        end
      end
      S_JS_CMP: begin
        cmp_req    = '{start: 1'b1, a: rdata, b: piv};
        state_next = S_JS_WAIT;
      end
      S_JS_WAIT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.ord == tvt_pkg::ORD_GT) begin
            j_next     = j - SW'(1);
            state_next = S_JS;
          end else begin
            state_next = S_SWP;
          end
        end
      end

      // Swap entries i and j
      S_SWP: begin
        if (i <= j) begin
          mem_raddr  = i[AW-1:0];
          state_next = S_SW1;
        end else begin
          state_next = S_PUSH1;
        end
      end
      S_SW1: begin
        ta_next    = rdata;
        mem_raddr  = j[AW-1:0];
        state_next = S_SW2;
      end
      S_SW2: begin
        mem_we     = 1'b1;
        mem_waddr  = i[AW-1:0];
        state_next = S_SW3;
      end
      S_SW3: begin
        mem_we     = 1'b1;
        mem_waddr  = j[AW-1:0];
        mem_wdata  = ta;
        i_next     = i_p1;
        j_next     = j - SW'(1);
        state_next = S_LOOP;
      end
      S_LOOP: state_next = (i <= j) ? S_IS : S_PUSH1;

      // Push right part, then left part so the left one pops first
      S_PUSH1: begin
        if (i < hi_s && top < CW'(TABLE_DEPTH)) begin
          stk_we    = 1'b1;
          stk_waddr = top[AW-1:0];
          stk_wdata = {i[AW-1:0], hi};
          top_next  = top + CW'(1);
        end
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        if (lo_s < j && top < CW'(TABLE_DEPTH)) begin
          stk_we    = 1'b1;
          stk_waddr = top[AW-1:0];
          stk_wdata = {lo, j[AW-1:0]};
          top_next  = top + CW'(1);
        end
        state_next = S_POP;
      end

      // Dedupe: clear the marks over the live entries
      S_CLR: begin
        mark_we    = 1'b1;
        mark_waddr = k[AW-1:0];
        k_next     = k + CW'(1);
        if (k + CW'(1) == count) begin
          i_next     = '0;
          state_next = S_DO;
        end
      end

      // Outer pass: each unmarked entry i marks later matches
      S_DO: begin
        if (i_p1 < cnt_s) begin
          mem_raddr  = i[AW-1:0];
          mark_raddr = i[AW-1:0];
          state_next = S_DO_M;
        end else begin
          k_next     = '0;
          j_next     = '0;
          state_next = S_CP_RD;
        end
      end
      S_DO_M: begin
        if (mark_rd) begin
          i_next     = i_p1;
          state_next = S_DO;
        end else begin
          ta_next    = rdata;
          j_next     = i_p1;
          state_next = S_DI;
        end
      end
      S_DI: begin
        if (j < cnt_s) begin
          mem_raddr  = j[AW-1:0];
          mark_raddr = j[AW-1:0];
          state_next = S_DI_M;
        end else begin
          i_next     = i_p1;
          state_next = S_DO;
        end
      end
      S_DI_M: begin
        if (mark_rd) begin
          j_next     = j + SW'(1);
          state_next = S_DI;
        end else begin
          cmp_req    = '{start: 1'b1, a: ta, b: rdata};
          state_next = S_DI_WAIT;
        end
      end
      S_DI_WAIT: begin
        if (cmp_rsp.done) begin
          if (cmp_rsp.ord == tvt_pkg::ORD_EQ) begin
            mark_we    = 1'b1;
            mark_waddr = j[AW-1:0];
            mark_wdata = 1'b1;
          end
          j_next     = j + SW'(1);
          state_next = S_DI;
        end
      end

      // Compact: j counts the kept entries
      S_CP_RD: begin
        if (k < count) begin
          mem_raddr  = k[AW-1:0];
          mark_raddr = k[AW-1:0];
          state_next = S_CP_WR;
        end else begin
          count_next = CW'(j);
          state_next = S_DONE;
        end
      end
      S_CP_WR: begin
        if (!mark_rd) begin
          mem_we    = 1'b1;
          mem_waddr = j[AW-1:0];
          j_next    = j + SW'(1);
        end
        k_next     = k + CW'(1);
        state_next = S_CP_RD;
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      top     <= '0;
      o_valid <= 1'b0;
      tol     <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      top   <= top_next;
      if (o_load) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
      if (cfg_we) tol <= cfg_wdata;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    k     <= k_next;
    i     <= i_next;
    j     <= j_next;
    m     <= m_next;
    last  <= last_next;
    lo    <= lo_next;
    hi    <= hi_next;
    vec_r <= vec_next;
    piv   <= piv_next;
    ta    <= ta_next;
    st_r  <= st_next;
    ri_r  <= ri_next;
  end

  // Result payload
  assign cntn32 = 32'(count);
  always_ff @(posedge clk) begin
    if (o_load) begin
      o_status <= st_r;
      o_index  <= ri32[tvt_pkg::RIDX_W-1:0];
      o_total  <= cntn32[tvt_pkg::TOTAL_W-1:0];
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.result_index = o_index;
  assign rsp.entry_total  = o_total;

  // Stores
  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rdata <= store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) marks[mark_waddr] <= mark_wdata;
    mark_rd <= marks[mark_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk[stk_waddr] <= stk_wdata;
    stk_rd <= stk[stk_raddr];
  end

endmodule

[hdl/tvt_checker.sv]
module tvt_checker #(
  parameter int TABLE_DEPTH = tvt_pkg::DEFAULT_DEPTH
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [tvt_pkg::STATUS_W-1:0]  rsp_status,
  input logic [tvt_pkg::RIDX_W-1:0]    rsp_result_index,
  input logic [tvt_pkg::TOTAL_W-1:0]   rsp_entry_total
);

  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_result_index) && $stable(rsp_entry_total))
    else $error("result changed while stalled");

  // One operation at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted a transaction while busy");

  // Failed operations report index zero
  a_fail_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != tvt_pkg::ST_OK |-> rsp_result_index == '0)
    else $error("nonzero index on failed operation");

  // A full table reports the full depth
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == tvt_pkg::ST_FULL |->
      rsp_entry_total == DEPTH32[tvt_pkg::TOTAL_W-1:0])
    else $error("table full with wrong entry total");

endmodule

bind tolerant_vector_table tvt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_tvt_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req.valid),
  .req_ready        (req.ready),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_status       (rsp.status),
  .rsp_result_index (rsp.result_index),
  .rsp_entry_total  (rsp.entry_total)
);
